// ===== hdl/aik_pkg.sv =====
// Shared types, constants and helpers for the inverse kinematics pipeline.
`default_nettype none
package aik_pkg;
    localparam int DEG_W = 9;
    localparam int CW = 36;    // cordic datapath width (values below 2^31 grown by gain)
    localparam int AW = 36;    // angle accumulator width, 2^-16 degree
    localparam logic signed [AW-1:0] DEG90 = 36'sd5898240;
    localparam logic signed [AW-1:0] DEG180 = 36'sd11796480;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_REACH = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_UPPER = 3'd0,
        REG_FORE  = 3'd1,
        REG_SH_H  = 3'd2,
        REG_SH_D  = 3'd3,
        REG_EFF_Y = 3'd4,
        REG_EFF_Z = 3'd5
    } t_reg_idx;

    function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AW-1:0] v;
        begin
            case (i)
                5'd0: v = 36'sd2949120;
                5'd1: v = 36'sd1740967;
                5'd2: v = 36'sd919879;
                5'd3: v = 36'sd466945;
                5'd4: v = 36'sd234379;
                5'd5: v = 36'sd117304;
                5'd6: v = 36'sd58666;
                5'd7: v = 36'sd29335;
                5'd8: v = 36'sd14668;
                5'd9: v = 36'sd7334;
                5'd10: v = 36'sd3667;
                5'd11: v = 36'sd1833;
                5'd12: v = 36'sd917;
                5'd13: v = 36'sd458;
                5'd14: v = 36'sd229;
                5'd15: v = 36'sd115;
                5'd16: v = 36'sd57;
                5'd17: v = 36'sd29;
                5'd18: v = 36'sd14;
                5'd19: v = 36'sd7;
                5'd20: v = 36'sd4;
                5'd21: v = 36'sd2;
                5'd22: v = 36'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hdl/aik_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module aik_isqrt import aik_pkg::*; #(
    parameter int IW = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic [IW-1:0]       i_v,
    output logic [IW/2-1:0]          o_r
);
    localparam int N = IW / 2;
    logic [IW-1:0] r_rem  [N+1];
    logic [N-1:0]  r_root [N+1];

    always_comb begin
        r_rem[0]  = i_v;
        r_root[0] = '0;
    end

    for (genvar s = 0; s < N; s++) begin : g_st
        logic [IW-1:0] trial;
        logic [N-1:0]  bitv;
        always_comb begin
            bitv  = N'(1) << (N - 1 - s);
            trial = IW'(r_root[s] | bitv) * IW'(r_root[s] | bitv);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (trial <= r_rem[s]) begin
                    r_root[s+1] <= r_root[s] | bitv;
                end else begin
                    r_root[s+1] <= r_root[s];
                end
                r_rem[s+1] <= r_rem[s];
            end
        end
    end
    assign o_r = r_root[N];
endmodule
`default_nettype wire

// ===== hdl/aik_cordic.sv =====
// Pipelined vectoring atan2 with quadrant prerotation and normalization.
`default_nettype none
module aik_cordic import aik_pkg::*; #(
    parameter int STAGES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [CW-1:0]  i_y,
    input  wire logic signed [CW-1:0]  i_x,
    output logic signed [AW-1:0]       o_ang
);
    localparam int NS = (STAGES < 24) ? STAGES : 24;
    logic signed [CW-1:0] r_px, r_py;
    logic signed [AW-1:0] r_pb;
    logic                 r_pz;
    logic signed [CW-1:0] n_px, n_py;
    logic signed [AW-1:0] n_pb;
    logic signed [CW-1:0] r_x [NS+1];
    logic signed [CW-1:0] r_y [NS+1];
    logic signed [AW-1:0] r_a [NS+1];
    logic                 r_z [NS+1];
    logic signed [CW-1:0] r_nx, r_ny;
    logic signed [AW-1:0] r_nb;
    logic                 r_nz;

    always_comb begin
        n_px = i_x;
        n_py = i_y;
        n_pb = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_px = i_y; n_py = -i_x; n_pb = DEG90;
            end else begin
                n_px = -i_y; n_py = i_x; n_pb = -DEG90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pb <= n_pb;
            r_pz <= (i_x == 0) && (i_y == 0);
        end
    end

    // normalize: double until a component magnitude reaches 2^30
    logic signed [CW-1:0] ax, ay, orv;
    logic [5:0]           lz;
    always_comb begin
        ax  = (r_px < 0) ? -r_px : r_px;
        ay  = (r_py < 0) ? -r_py : r_py;
        orv = ax | ay;
        lz  = '0;
        for (int k = 0; k <= 30; k++) begin
            if (orv[30-k] && lz == 6'd0 && ((orv >> (31 - k)) == '0)) begin
                lz = 6'(k);
            end
        end
        if (|orv[CW-1:30]) lz = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx <= r_px <<< lz;
            r_ny <= r_py <<< lz;
            r_nb <= r_pb;
            r_nz <= r_pz;
        end
    end

    always_comb begin
        r_x[0] = r_nx;
        r_y[0] = r_ny;
        r_a[0] = r_nb;
        r_z[0] = r_nz;
    end

    for (genvar i = 0; i < NS; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + atan_tab(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - atan_tab(5'(i));
                end
                r_z[i+1] <= r_z[i];
            end
        end
    end
    assign o_ang = r_z[NS] ? '0 : r_a[NS];
endmodule
`default_nettype wire

// ===== hdl/arm_inverse_kinematics_unit.sv =====
// Top level: configuration registers, front end, root and cordic pipelines, output.
//
// Usage:
//   Items enter on start with i_target_x/y/z; busy is always low, so one
//   item can be taken every cycle. Each item yields one result, shown for one
//   cycle with o_done high. The receiver cannot stall the block.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high. Write only while the pipeline is empty.
//   Depth: 5 front end stages, 32 square root stages, 2 + CORDIC_STAGES
//   (capped at 24) atan2 stages, and 2 output stages; throughput one item
//   per cycle, set by the fully pipelined root and atan2 units.
//   Reset (i_rst_n low, synchronous) loads the default link lengths and
//   offsets and clears all valid bits; items in flight are dropped.
//   Angles: 1/128 degree. Status 0 ok, 1 out of reach, 2 zero target.
//
`default_nettype none
module arm_inverse_kinematics_unit import aik_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [13:0] i_target_x,
    input  wire logic signed [13:0] i_target_y,
    input  wire logic signed [13:0] i_target_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [13:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [15:0]      o_base_angle,
    output logic signed [15:0]      o_shoulder_angle,
    output logic [14:0]             o_elbow_angle,
    output logic signed [16:0]      o_wrist_angle,
    output logic [1:0]              o_status
);
    localparam int NS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int LAT = 32 + NS + 2;   // root plus cordic depth

    logic [12:0]        r_ua, r_fa;
    logic signed [13:0] r_shh, r_shd, r_ey, r_ez;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ua <= 13'd3496; r_fa <= 13'd2320;
            r_shh <= '0; r_shd <= '0; r_ey <= '0; r_ez <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_UPPER: r_ua  <= i_cfg_data[12:0];
                REG_FORE:  r_fa  <= i_cfg_data[12:0];
                REG_SH_H:  r_shh <= i_cfg_data;
                REG_SH_D:  r_shd <= i_cfg_data;
                REG_EFF_Y: r_ey  <= i_cfg_data;
                REG_EFF_Z: r_ez  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: squares
    logic               r1_v;
    logic signed [13:0] r1_x, r1_y, r1_z;
    logic [27:0]        r1_xx, r1_yy, r1_zz;
    logic [25:0]        r1_aa, r1_bb;
    logic               r1_ab0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= start;
        r1_x <= i_target_x; r1_y <= i_target_y; r1_z <= i_target_z;
        r1_xx <= 28'(i_target_x) * 28'(i_target_x);
        r1_yy <= 28'(i_target_y) * 28'(i_target_y);
        r1_zz <= 28'(i_target_z) * 28'(i_target_z);
        r1_aa <= 26'(r_ua) * 26'(r_ua);
        r1_bb <= 26'(r_fa) * 26'(r_fa);
        r1_ab0 <= (r_ua == 0) || (r_fa == 0);
    end

    // stage 2: sums
    logic               r2_v, r2_ab0;
    logic signed [13:0] r2_x, r2_y, r2_z;
    logic [29:0]        r2_s, r2_h;
    logic signed [30:0] r2_n2, r2_n3;
    logic [25:0]        r2_aa, r2_bb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_x <= r1_x; r2_y <= r1_y; r2_z <= r1_z;
        r2_h <= 30'(r1_xx) + 30'(r1_yy);
        r2_s <= 30'(r1_xx) + 30'(r1_yy) + 30'(r1_zz);
        r2_n2 <= 31'(r1_aa) + 31'(r1_xx) + 31'(r1_yy) + 31'(r1_zz) - 31'(r1_bb);
        r2_n3 <= 31'(r1_aa) + 31'(r1_bb) - 31'(r1_xx) - 31'(r1_yy) - 31'(r1_zz);
        r2_aa <= r1_aa; r2_bb <= r1_bb; r2_ab0 <= r1_ab0;
    end

    // stage 3: products (split into 2 stages to keep multipliers narrow)
    logic               r3_v, r3_ab0;
    logic signed [13:0] r3_x, r3_y, r3_z;
    logic [29:0]        r3_s, r3_h;
    logic signed [30:0] r3_n2, r3_n3;
    logic [30:0]        r3_m2, r3_m3;
    logic [57:0]        r3_q2, r3_q3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_x <= r2_x; r3_y <= r2_y; r3_z <= r2_z;
        r3_s <= r2_s; r3_h <= r2_h; r3_n2 <= r2_n2; r3_n3 <= r2_n3;
        r3_m2 <= r2_n2[30] ? 31'(-r2_n2) : 31'(r2_n2);
        r3_m3 <= r2_n3[30] ? 31'(-r2_n3) : 31'(r2_n3);
        r3_q2 <= 58'(r2_aa) * 58'(r2_s);
        r3_q3 <= 58'(r2_aa) * 58'(r2_bb);
        r3_ab0 <= r2_ab0;
    end

    logic               r4_v, r4_ab0;
    logic signed [13:0] r4_x, r4_y, r4_z;
    logic [29:0]        r4_s, r4_h;
    logic signed [30:0] r4_n2, r4_n3;
    logic [61:0]        r4_mm2, r4_mm3;
    logic [59:0]        r4_q2, r4_q3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else r4_v <= r3_v;
        r4_x <= r3_x; r4_y <= r3_y; r4_z <= r3_z;
        r4_s <= r3_s; r4_h <= r3_h; r4_n2 <= r3_n2; r4_n3 <= r3_n3;
        r4_mm2 <= 62'(r3_m2) * 62'(r3_m2);
        r4_mm3 <= 62'(r3_m3) * 62'(r3_m3);
        r4_q2 <= {r3_q2, 2'b00};
        r4_q3 <= {r3_q3, 2'b00};
        r4_ab0 <= r3_ab0;
    end

    // stage 5: reach test and scale shift selection
    function automatic logic [4:0] scl(input logic [59:0] q);
        logic [4:0] k;
        begin
            k = 5'd16;
            for (int j = 15; j >= 0; j--) begin
                if ((62'(q) << (2 * j)) >= (62'(1) << 58)) k = 5'(j);
            end
            return k;
        end
    endfunction

    logic               r5_v;
    t_status            r5_st;
    logic signed [13:0] r5_x, r5_y;
    logic signed [49:0] r5_l1, r5_l2, r5_l3;
    logic [63:0]        r5_sq1, r5_sq2, r5_sq3;
    logic [4:0]         k1, k2, k3;
    logic [59:0]        d2, d3;
    always_comb begin
        k1 = scl(60'(r4_s));
        k2 = scl(r4_q2);
        k3 = scl(r4_q3);
        d2 = r4_q2 - 60'(r4_mm2);
        d3 = r4_q3 - 60'(r4_mm3);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else r5_v <= r4_v;
        r5_x <= r4_x; r5_y <= r4_y;
        if (r4_s == 0) r5_st <= ST_ZERO;
        else if (r4_ab0 || r4_mm2 > 62'(r4_q2) || r4_mm3 > 62'(r4_q3)) r5_st <= ST_REACH;
        else r5_st <= ST_OK;
        r5_l1 <= 50'(r4_z) <<< k1;
        r5_l2 <= 50'(r4_n2) <<< k2;
        r5_l3 <= 50'(r4_n3) <<< k3;
        r5_sq1 <= 64'(r4_h) << (2 * k1);
        r5_sq2 <= 64'(d2) << (2 * k2);
        r5_sq3 <= 64'(d3) << (2 * k3);
    end

    // square roots
    logic [31:0] rt1, rt2, rt3;
    aik_isqrt #(.IW(64)) u_sq1 (.i_clk, .i_en(1'b1), .i_v(r5_sq1), .o_r(rt1));
    aik_isqrt #(.IW(64)) u_sq2 (.i_clk, .i_en(1'b1), .i_v(r5_sq2), .o_r(rt2));
    aik_isqrt #(.IW(64)) u_sq3 (.i_clk, .i_en(1'b1), .i_v(r5_sq3), .o_r(rt3));

    // delay lines over root depth
    logic signed [13:0] d_x [33];
    logic signed [13:0] d_y [33];
    logic signed [35:0] d_l1 [33];
    logic signed [35:0] d_l2 [33];
    logic signed [35:0] d_l3 [33];
    always_comb begin
        d_x[0] = r5_x; d_y[0] = r5_y;
        d_l1[0] = 36'(r5_l1); d_l2[0] = 36'(r5_l2); d_l3[0] = 36'(r5_l3);
    end
    for (genvar i = 0; i < 32; i++) begin : g_d
        always_ff @(posedge i_clk) begin
            d_x[i+1] <= d_x[i]; d_y[i+1] <= d_y[i];
            d_l1[i+1] <= d_l1[i]; d_l2[i+1] <= d_l2[i]; d_l3[i+1] <= d_l3[i];
        end
    end

    logic signed [CW-1:0] wn, wd, wy, wx;
    always_comb begin
        wn = CW'(r_ez) - CW'(r_shh);
        wd = CW'(r_shd) - CW'(r_ey);
        wy = (wd < 0) ? -wn : wn;
        wx = (wd < 0) ? -wd : wd;
    end

    logic signed [AW-1:0] a_b, a_1, a_2, a_3, a_w;
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cb (.i_clk, .i_en(1'b1),
        .i_y(-CW'(d_x[32])), .i_x(CW'(d_y[32])), .o_ang(a_b));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_c1 (.i_clk, .i_en(1'b1),
        .i_y(d_l1[32]), .i_x(CW'(rt1)), .o_ang(a_1));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_c2 (.i_clk, .i_en(1'b1),
        .i_y(CW'(rt2)), .i_x(d_l2[32]), .o_ang(a_2));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_c3 (.i_clk, .i_en(1'b1),
        .i_y(CW'(rt3)), .i_x(d_l3[32]), .o_ang(a_3));
    aik_cordic #(.STAGES(CORDIC_STAGES)) u_cw (.i_clk, .i_en(1'b1),
        .i_y(wy), .i_x(wx), .o_ang(a_w));

    // valid, status, base and wrist special cases alongside
    logic    d_v  [LAT+1];
    t_status d_st [LAT+1];
    logic    d_bn [LAT+1];
    logic    d_wz [LAT+1];
    logic    d_ws [LAT+1];
    always_comb begin
        d_v[0] = r5_v; d_st[0] = r5_st;
        d_bn[0] = 1'b0; d_wz[0] = 1'b0; d_ws[0] = 1'b0;
    end
    for (genvar i = 0; i < LAT; i++) begin : g_v
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) d_v[i+1] <= 1'b0;
            else d_v[i+1] <= d_v[i];
            d_st[i+1] <= d_st[i];
            if (i == 32) begin
                d_bn[i+1] <= (d_x[32] == 0) && (d_y[32] < 0);
                d_wz[i+1] <= (wd == 0);
                d_ws[i+1] <= wn[CW-1];
            end else begin
                d_bn[i+1] <= d_bn[i];
                d_wz[i+1] <= d_wz[i];
                d_ws[i+1] <= d_ws[i];
            end
        end
    end

    // combine
    logic                 r6_v;
    t_status              r6_st;
    logic signed [AW-1:0] r6_b, r6_t2, r6_t3, r6_w;
    logic signed [AW-1:0] wsel;
    always_comb begin
        if (d_wz[LAT]) wsel = a_w == 0 ? '0 : (d_ws[LAT] ? -DEG90 : DEG90);
        else wsel = a_w;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else r6_v <= d_v[LAT];
        r6_st <= d_st[LAT];
        r6_b  <= d_bn[LAT] ? DEG180 : a_b;
        r6_t2 <= DEG90 - a_1 - a_2;
        r6_t3 <= DEG180 - a_3;
        r6_w  <= wsel;
    end

    function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v,
                                                 input logic signed [AW-1:0] lo,
                                                 input logic signed [AW-1:0] hi);
        logic signed [AW-1:0] r;
        begin
            r = (v + AW'(256)) >>> DEG_W;
            if (r < lo) r = lo;
            if (r > hi) r = hi;
            return r;
        end
    endfunction

    logic signed [AW-1:0] t4;
    assign t4 = DEG90 - r6_t2 - r6_t3 + r6_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= r6_v;
        o_status <= r6_st;
        if (r6_st == ST_OK) begin
            o_base_angle     <= 16'(rnd(r6_b, -36'sd23040, 36'sd23040));
            o_shoulder_angle <= 16'(rnd(r6_t2, -36'sd23040, 36'sd23040));
            o_elbow_angle    <= 15'(rnd(r6_t3, 36'sd0, 36'sd23040));
            o_wrist_angle    <= 17'(rnd(t4, -36'sd57600, 36'sd57600));
        end else begin
            o_base_angle <= '0; o_shoulder_angle <= '0;
            o_elbow_angle <= '0; o_wrist_angle <= '0;
        end
    end
endmodule
`default_nettype wire

// ===== tb/arm_inverse_kinematics_unit_test.sv =====
// Testbench for arm_inverse_kinematics_unit: directed rows and predictor-checked random targets.
`timescale 1ns / 1ps
module arm_inverse_kinematics_unit_test;
    import aik_pkg::*;

    typedef struct {
        logic signed [15:0] base;
        logic signed [15:0] shoulder;
        logic [14:0]        elbow;
        logic signed [16:0] wrist;
        logic [1:0]         status;
    } t_pose;

    typedef struct {
        int    x, y, z;
        bit    fixed;
        t_pose pose;
    } t_row;

    localparam int STAGES = 16;
    localparam longint DEG = 65536;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [13:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [13:0] i_cfg_data = '0;
    logic o_done;
    logic signed [15:0] o_base_angle, o_shoulder_angle;
    logic [14:0] o_elbow_angle;
    logic signed [16:0] o_wrist_angle;
    logic [1:0] o_status;

    arm_inverse_kinematics_unit #(.CORDIC_STAGES(STAGES)) u_top (.*);

    always #1 i_clk = ~i_clk;

    longint arm_upper, arm_fore, sh_height, sh_dist, eff_y, eff_z;
    longint atan_steps [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    t_pose pending_poses [$];
    bit    use_fixed = 0;
    t_pose fixed_pose;
    int    n_errors = 0;
    int    idle_cycles = 0;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint base = 0, ang = 0, t, xs, ys;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; base = 90 * DEG;
            end else begin
                t = x; x = -y; y = t; base = -90 * DEG;
            end
        end
        while (abs64(x) < (64'sd1 << 30) && abs64(y) < (64'sd1 << 30)) begin
            x *= 2;
            y *= 2;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; ang += atan_steps[i];
            end else begin
                x = x - ys; y = y + xs; ang -= atan_steps[i];
            end
        end
        return base + ang;
    endfunction

    function automatic void fit_pair(input longint lin, input longint unsigned sq,
                                     input longint unsigned q, output longint ls,
                                     output longint rs);
        int k = 0;
        while (k < 16 && q < (64'd1 << 58)) begin
            q <<= 2;
            k++;
        end
        ls = lin * (64'sd1 << k);
        rs = longint'(int_root(sq << (2 * k)));
    endfunction

    function automatic longint to_units(longint v, longint lo, longint hi);
        longint r = (v + 256) >>> 9;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic t_pose predict_pose(longint x, longint y, longint z);
        t_pose p = '{0, 0, 0, 0, ST_OK};
        longint a = arm_upper, b = arm_fore, s, n2, n3, l, r, phi1, phi2, phi3;
        longint w, t2, t3, t4, wn, wd, bs;
        longint unsigned q2, q3, m2, m3;
        s = x * x + y * y + z * z;
        if (s == 0) begin
            p.status = ST_ZERO;
            return p;
        end
        n2 = a * a + s - b * b;
        n3 = a * a + b * b - s;
        q2 = 4 * longint'(a * a) * s;
        q3 = 4 * longint'(a * a) * (b * b);
        m2 = abs64(n2);
        m3 = abs64(n3);
        if (a == 0 || b == 0 || m2 * m2 > q2 || m3 * m3 > q3) begin
            p.status = ST_REACH;
            return p;
        end
        wn = eff_z - sh_height;
        wd = sh_dist - eff_y;
        bs = angle_of(-x, y);
        if (x == 0 && y < 0) bs = 180 * DEG;
        fit_pair(z, x * x + y * y, s, l, r);
        phi1 = angle_of(l, r);
        fit_pair(n2, q2 - m2 * m2, q2, l, r);
        phi2 = angle_of(r, l);
        fit_pair(n3, q3 - m3 * m3, q3, l, r);
        phi3 = angle_of(r, l);
        if (wd == 0) w = wn > 0 ? 90 * DEG : (wn < 0 ? -90 * DEG : 0);
        else if (wd > 0) w = angle_of(wn, wd);
        else w = angle_of(-wn, -wd);
        t2 = 90 * DEG - phi1 - phi2;
        t3 = 180 * DEG - phi3;
        t4 = 90 * DEG - t2 - t3 + w;
        p.base = 16'(to_units(bs, -23040, 23040));
        p.shoulder = 16'(to_units(t2, -23040, 23040));
        p.elbow = 15'(to_units(t3, 0, 23040));
        p.wrist = 17'(to_units(t4, -57600, 57600));
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arm_upper <= 3496; arm_fore <= 2320;
            sh_height <= 0; sh_dist <= 0; eff_y <= 0; eff_z <= 0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_UPPER: arm_upper <= longint'(i_cfg_data[12:0]);
                REG_FORE:  arm_fore <= longint'(i_cfg_data[12:0]);
                REG_SH_H:  sh_height <= longint'($signed(i_cfg_data));
                REG_SH_D:  sh_dist <= longint'($signed(i_cfg_data));
                REG_EFF_Y: eff_y <= longint'($signed(i_cfg_data));
                REG_EFF_Z: eff_z <= longint'($signed(i_cfg_data));
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && start && !busy)
            pending_poses.push_back(use_fixed ? fixed_pose
                : predict_pose(i_target_x, i_target_y, i_target_z));
        if (i_rst_n && o_done) begin
            if (pending_poses.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = pending_poses.pop_front();
                if (o_base_angle !== want.base)
                    report_mismatch("base", o_base_angle, want.base);
                if (o_shoulder_angle !== want.shoulder)
                    report_mismatch("shoulder", o_shoulder_angle, want.shoulder);
                if (o_elbow_angle !== want.elbow)
                    report_mismatch("elbow", o_elbow_angle, want.elbow);
                if (o_wrist_angle !== want.wrist)
                    report_mismatch("wrist", o_wrist_angle, want.wrist);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)
                || pending_poses.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("arm_inverse_kinematics_unit verification failed");
            $finish;
        end
    end

    task automatic send_target(int x, int y, int z);
        i_target_x <= 14'(x);
        i_target_y <= 14'(y);
        i_target_z <= 14'(z);
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic pause_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 14'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_arm(int a, int b, int hh, int hd, int ey, int ez);
        write_reg(REG_UPPER, a);
        write_reg(REG_FORE, b);
        write_reg(REG_SH_H, hh);
        write_reg(REG_SH_D, hd);
        write_reg(REG_EFF_Y, ey);
        write_reg(REG_EFF_Z, ez);
    endtask

    function automatic int pick(int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    task automatic random_targets(int count);
        int sent = 0, burst, reach, x, y, z;
        reach = int'(arm_upper + arm_fore);
        if (reach > 8191 || reach == 0) reach = 8191;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < count) begin
                if ($urandom_range(0, 4) == 0) begin
                    x = pick(8192) % 8192; y = pick(8192) % 8192;
                    z = int'($urandom_range(0, 16383)) - 8192;
                end else begin
                    x = pick(reach); y = pick(reach); z = pick(reach);
                end
                send_target(x, y, z);
                sent++;
                burst--;
            end
            if (sent == count / 2) drain();
            else if ($urandom_range(0, 3) != 0) pause_cycles($urandom_range(1, 12));
        end
        drain();
    endtask

    t_row rows [$];

    initial begin
        t_pose zp = '{0, 0, 0, 0, ST_OK};
        t_pose rp = '{0, 0, 0, 0, ST_REACH};
        t_pose np = '{0, 0, 0, 0, ST_ZERO};
        rows = '{
            '{0, 0, 0, 1, np}, '{8191, 8191, 8191, 1, rp}, '{-8192, -8192, -8192, 1, rp},
            '{8191, 0, 0, 1, rp}, '{0, 0, -8192, 1, rp}, '{1, 0, 0, 1, rp},
            '{0, -3000, 0, 0, zp}, '{0, 3000, 0, 0, zp}, '{3000, 3000, 1000, 0, zp},
            '{-4000, 100, -2000, 0, zp}, '{1176, 0, 0, 0, zp}, '{0, 5816, 0, 0, zp},
            '{0, 0, 5816, 0, zp}, '{0, 0, -5816, 0, zp}, '{-2000, -2000, 500, 0, zp},
            '{4112, 4112, 0, 0, zp}, '{0, 1175, 0, 0, zp}, '{5817, 0, 0, 0, zp}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            use_fixed <= rows[i].fixed;
            fixed_pose <= rows[i].pose;
            send_target(rows[i].x, rows[i].y, rows[i].z);
            use_fixed <= 1'b0;
            if ($urandom_range(0, 2) == 0) pause_cycles($urandom_range(1, 5));
        end
        drain();
        random_targets(200);

        load_arm(8191, 8191, -8192, 8191, -8192, 8191);
        random_targets(130);
        load_arm(1, 1, 8191, -8192, 8191, -8192);
        for (int i = -2; i <= 2; i++) send_target(i, 1, -i);
        random_targets(60);
        load_arm(3496, 2320, 100, 500, 500, 300);
        random_targets(110);
        load_arm(2000, 3000, 300, -40, -40, 100);
        random_targets(110);
        load_arm(0, 2320, 0, 0, 0, 0);
        use_fixed <= 1'b1;
        fixed_pose <= rp;
        send_target(1000, 1000, 1000);
        use_fixed <= 1'b0;
        random_targets(30);
        load_arm(5000, 0, 0, 0, 0, 0);
        random_targets(30);

        if (n_errors == 0)
            $display("arm_inverse_kinematics_unit verification clean");
        else
            $display("arm_inverse_kinematics_unit verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/aik_pkg.sv
hdl/aik_isqrt.sv
hdl/aik_cordic.sv
hdl/arm_inverse_kinematics_unit.sv
tb/arm_inverse_kinematics_unit_test.sv
